@@ hdl/tdf_pkg.sv @@
// shared types and constants for the temperature display formatter
package tdf_pkg;

  // input reading and result display fields
  typedef struct packed {
    logic signed [15:0] raw_temp;
    logic               sensor_ok;
  } tdf_in_t;

  typedef struct packed {
    logic       error_shown;
    logic       unit_is_f;
    logic [3:0] digit_ones;
    logic [3:0] digit_tens;
    logic [3:0] digit_hundreds;
    logic       minus_sign;
  } tdf_out_t;

  // side data that rides along with the magnitude
  typedef struct packed {
    logic err;
    logic unit_f;
    logic neg;
  } tdf_side_t;

  localparam int TempScale = 16;
  localparam int LimitDeg  = 200;
  localparam int FOffset   = 32;
  localparam int FDenom    = 5;

  // range limit in sixteenths of a degree, fahrenheit offset in sixteenths of a degree times five
  localparam logic signed [19:0] LIMIT_HI   = 20'(LimitDeg * TempScale);
  localparam logic signed [19:0] LIMIT_LO   = -20'(LimitDeg * TempScale);
  localparam logic signed [19:0] F_OFFSET16 = 20'(TempScale * FDenom * FOffset);

  // x / 5 == (x * RECIP5) >> RECIP5_SHIFT for every x below 2**16
  localparam logic [15:0] RECIP5       = 16'd52429;
  localparam int          RECIP5_SHIFT = 18;

  // x / 10 == (x * RECIP10) >> RECIP10_SHIFT for x below 128
  localparam logic [7:0] RECIP10       = 8'd205;
  localparam int         RECIP10_SHIFT = 11;

  localparam logic [3:0] TEN = 4'd10;

endpackage

@@ hdl/tdf_bcd.sv @@
// two-stage split of a 9-bit magnitude into decimal digits, with result assembly
module tdf_bcd import tdf_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      mag_valid,
  input  logic [8:0] mag,
  input  tdf_side_t side,
  output logic      res_valid,
  output tdf_out_t  res
);

  logic       s1_valid_r;
  logic [1:0] s1_hund_r;
  logic [6:0] s1_rem_r;
  tdf_side_t  s1_side_r;

  logic [1:0]  hund_nxt;
  logic [6:0]  rem_nxt;
  logic [8:0]  sub;

  // hundreds by compare, an in-range magnitude never reaches 400
  always_comb begin
    if (mag >= 9'd300) begin
      hund_nxt = 2'd3;
      sub      = 9'd300;
    end else if (mag >= 9'd200) begin
      hund_nxt = 2'd2;
      sub      = 9'd200;
    end else if (mag >= 9'd100) begin
      hund_nxt = 2'd1;
      sub      = 9'd100;
    end else begin
      hund_nxt = 2'd0;
      sub      = 9'd0;
    end
    rem_nxt = 7'(mag - sub);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= mag_valid;
    end
    s1_hund_r <= hund_nxt;
    s1_rem_r  <= rem_nxt;
    s1_side_r <= side;
  end

  logic [14:0] prod10;
  logic [3:0]  tens;
  logic [6:0]  tens_x10;
  logic [3:0]  ones;
  tdf_out_t    res_nxt;
  logic        res_valid_r;
  tdf_out_t    res_r;

  always_comb begin
    prod10   = 15'(s1_rem_r) * 15'(RECIP10);
    tens     = 4'(prod10 >> RECIP10_SHIFT);
    tens_x10 = 7'(tens) * 7'(TEN);
    ones     = 4'(s1_rem_r - tens_x10);
    res_nxt  = '0;
    if (s1_side_r.err) begin
      res_nxt.error_shown = 1'b1;
    end else begin
      res_nxt.unit_is_f      = s1_side_r.unit_f;
      res_nxt.digit_ones     = ones;
      res_nxt.digit_tens     = tens;
      res_nxt.digit_hundreds = 4'(s1_hund_r);
      res_nxt.minus_sign     = s1_side_r.neg;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else begin
      res_valid_r <= s1_valid_r;
    end
    res_r <= res_nxt;
  end

  assign res_valid = res_valid_r;
  assign res       = res_r;

endmodule

@@ hdl/temperature_display_formatter.sv @@
// top level of the temperature display formatter: conversion pipeline and digit split
//
//  channel   ports                                  transfer when
//  -------   -----------------------------------    ---------------------
//  input     start, busy, in_data                   start high, busy low
//  result    out_valid, out_data                    out_valid high
//  config    cfg_wr_en, cfg_wr_data                 cfg_wr_en high
//
// one reading enters every cycle; its result leaves from the output register of the last stage
// four register stages: range check and, in fahrenheit, 9*t+2560, divide by five in fahrenheit
// with rounding, hundreds split, tens and ones split into the output register
// busy is always low: the receiver takes every result so nothing ever stalls
// synchronous active-low reset clears the unit bit and all stage valid bits
module temperature_display_formatter import tdf_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  tdf_in_t  in_data,
  output logic     out_valid,
  output tdf_out_t out_data,
  input  logic     cfg_wr_en,
  input  logic     cfg_wr_data
);

  // unit select register
  logic use_f_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      use_f_r <= 1'b0;
    end else if (cfg_wr_en) begin
      use_f_r <= cfg_wr_data;
    end
  end

  // no back pressure anywhere in the pipe
  assign busy = 1'b0;

  logic in_fire;
  assign in_fire = start & ~busy;

  // stage 1: range check, optional 9*t + 2560, sign and magnitude of numerator
  logic signed [19:0] t_ext;
  logic signed [19:0] num;
  logic               err_nxt;
  logic               num_neg;
  logic        [19:0] num_abs;

  always_comb begin
    t_ext   = 20'(in_data.raw_temp);
    err_nxt = ~in_data.sensor_ok | (t_ext < LIMIT_LO) | (t_ext > LIMIT_HI);
    // times nine as shift and add
    if (use_f_r) begin
      num = (t_ext <<< 3) + t_ext + F_OFFSET16;
    end else begin
      num = t_ext;
    end
    num_neg = num[19];
    num_abs = num_neg ? 20'(-num) : 20'(num);
  end

  logic        s1_valid_r;
  logic        s1_err_r;
  logic        s1_unit_r;
  logic        s1_neg_r;
  logic [14:0] s1_abs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_fire;
    end
    s1_err_r  <= err_nxt;
    s1_unit_r <= use_f_r;
    s1_neg_r  <= num_neg;
    // in range the magnitude stays below 2**15; out of range it is masked later
    s1_abs_r  <= num_abs[14:0];
  end

  // stage 2: in fahrenheit divide by five toward zero, round half away, drop four fraction bits
  logic [30:0] prod5;
  logic [12:0] quot;
  logic [13:0] rnd;
  logic [8:0]  mag_nxt;
  logic        neg_nxt;

  always_comb begin
    prod5 = 31'(s1_abs_r) * 31'(RECIP5);
    if (s1_unit_r) begin
      quot = 13'(prod5 >> RECIP5_SHIFT);
    end else begin
      quot = s1_abs_r[12:0];
    end
    // rounding on the magnitude equals rounding half away from zero on the value
    rnd     = 14'(quot) + 14'(TempScale / 2);
    mag_nxt = rnd[12:4];
    // a small negative numerator truncates to zero and is then not negative
    neg_nxt = s1_neg_r & (quot != 13'd0);
  end

  logic      s2_valid_r;
  logic [8:0] s2_mag_r;
  tdf_side_t s2_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s1_valid_r;
    end
    s2_mag_r         <= mag_nxt;
    s2_side_r.err    <= s1_err_r;
    s2_side_r.unit_f <= s1_unit_r;
    s2_side_r.neg    <= neg_nxt;
  end

  // stages 3 and 4: decimal digits and the output register
  tdf_bcd u_bcd (
    .clk       (clk),
    .rst_n     (rst_n),
    .mag_valid (s2_valid_r),
    .mag       (s2_mag_r),
    .side      (s2_side_r),
    .res_valid (out_valid),
    .res       (out_data)
  );

endmodule
